[rtl/running_median_rank_filter_assert.svh]
// Assertion macros for the running median rank filter.
`ifndef RUNNING_MEDIAN_RANK_FILTER_ASSERT_SVH
`define RUNNING_MEDIAN_RANK_FILTER_ASSERT_SVH
`ifndef SYNTH
`define RMRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rmrf assertion failed");
`define RMRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rmrf assertion failed");
`else
`define RMRF_ASSERT_NOW(label, ante, cons)
`define RMRF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/rmrf_pkg.sv]
package rmrf_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SAMPLE_W   = 32;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [ADDR_W-1:0] ADDR_WINDOW_LENGTH  = 3'd0;
    localparam logic [CNT_W-1:0]  WINDOW_LENGTH_RESET = CNT_W'(5);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [IDX_W-1:0]           t_idx;

    typedef struct packed {
        logic    shift;
        logic    count;
        t_idx    bcast_idx;
        t_sample bcast;
        t_cnt    rank_sel;
        t_cnt    len;
    } t_cell_ctl;

endpackage

[rtl/running_median_rank_filter.sv]
// Running median over the newest N samples (N = window_length, 0 reads as 1, above 64
// reads as 64). Each item shifts its sample into a row of 64 cells; once N samples have
// arrived since the last restart (tuser high), the block broadcasts the N window samples
// one per cycle along the row so that every cell counts its own rank, then picks the cell
// of rank (N+1)/2 (lower median for even N). An item that gives no result is done in
// ST_IDLE; one with a result passes accept, rank counting and select, set by the single
// broadcast path of the cell row; no new item is taken until it is through. The result
// waits in an output register; a further result stalls the block only while it is full.
`include "running_median_rank_filter_assert.svh"

module running_median_rank_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,  // [31:0] sample
    input  logic                                s_axis_tuser,  // [0] restart
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // [31:0] median
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rmrf_pkg::ADDR_W-1:0]         paddr,
    input  logic [rmrf_pkg::DATA_W-1:0]         pwdata,
    output logic [rmrf_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SELECT
    } t_state;

    t_state            r_state;
    rmrf_pkg::t_cnt    r_window_length;
    rmrf_pkg::t_cnt    r_fill;
    rmrf_pkg::t_idx    r_k;
    logic              r_out_valid;
    rmrf_pkg::t_sample r_out_data;

    rmrf_pkg::t_cnt    len;
    rmrf_pkg::t_cnt    n_fill;
    logic              accept;
    logic              emit;
    logic              cfg_write;
    rmrf_pkg::t_cell_ctl ctl;
    rmrf_pkg::t_sample cell_sample [rmrf_pkg::MAX_WINDOW];
    rmrf_pkg::t_sample cell_probe  [rmrf_pkg::MAX_WINDOW];
    logic [rmrf_pkg::MAX_WINDOW-1:0] hit;
    rmrf_pkg::t_sample median;

    always_comb begin
        if (r_window_length == '0) begin
            len = rmrf_pkg::CNT_W'(1);
        end else if (r_window_length > rmrf_pkg::CNT_W'(rmrf_pkg::MAX_WINDOW)) begin
            len = rmrf_pkg::CNT_W'(rmrf_pkg::MAX_WINDOW);
        end else begin
            len = r_window_length;
        end
    end

    always_comb begin
        if (s_axis_tuser) begin
            n_fill = rmrf_pkg::CNT_W'(1);
        end else if (r_fill < rmrf_pkg::CNT_W'(rmrf_pkg::MAX_WINDOW)) begin
            n_fill = r_fill + rmrf_pkg::CNT_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign emit          = (n_fill >= len);
    assign cfg_write     = psel && penable && pwrite && pready &&
                           (paddr == rmrf_pkg::ADDR_WINDOW_LENGTH);
    assign pready        = 1'b1;
    assign prdata        = (paddr == rmrf_pkg::ADDR_WINDOW_LENGTH) ?
                           rmrf_pkg::DATA_W'(r_window_length) : '0;

    always_comb begin
        ctl.shift     = accept;
        ctl.count     = (r_state == ST_COUNT);
        ctl.bcast_idx = r_k;
        ctl.bcast     = cell_probe[0];
        ctl.rank_sel  = (len + rmrf_pkg::CNT_W'(1)) >> 1;
        ctl.len       = len;
    end

    for (genvar g = 0; g < rmrf_pkg::MAX_WINDOW; g++) begin : g_cell
        rmrf_pkg::t_sample prev_sample;
        rmrf_pkg::t_sample next_probe;
        if (g == 0) begin : g_head
            assign prev_sample = s_axis_tdata;
        end else begin : g_body
            assign prev_sample = cell_sample[g-1];
        end
        if (g == rmrf_pkg::MAX_WINDOW - 1) begin : g_tail
            assign next_probe = '0;
        end else begin : g_link
            assign next_probe = cell_probe[g+1];
        end
        rmrf_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_index       (rmrf_pkg::IDX_W'(g)),
            .i_prev_sample (prev_sample),
            .i_next_probe  (next_probe),
            .o_sample      (cell_sample[g]),
            .o_probe       (cell_probe[g]),
            .o_hit         (hit[g])
        );
    end

    always_comb begin
        median = '0;
        for (int i = 0; i < rmrf_pkg::MAX_WINDOW; i++) begin
            median = median | (hit[i] ? cell_sample[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_window_length <= rmrf_pkg::WINDOW_LENGTH_RESET;
            r_fill          <= '0;
            r_k             <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_window_length <= pwdata[rmrf_pkg::CNT_W-1:0];
            end
            if (m_axis_tvalid && m_axis_tready && (r_state != ST_SELECT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_fill <= n_fill;
                        r_k    <= '0;
                        if (emit) begin
                            r_state <= ST_COUNT;
                        end
                    end
                end
                ST_COUNT: begin
                    r_k <= r_k + rmrf_pkg::IDX_W'(1);
                    if ({1'b0, r_k} == len - rmrf_pkg::CNT_W'(1)) begin
                        r_state <= ST_SELECT;
                    end
                end
                ST_SELECT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= median;
                        r_state     <= ST_IDLE;
                    end else if (m_axis_tvalid && m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `RMRF_ASSERT_NOW(a_one_median, r_state == ST_SELECT, $onehot(hit))
    `RMRF_ASSERT_NOW(a_count_in_window, r_state == ST_COUNT, {1'b0, r_k} < len)
    `RMRF_ASSERT_NEXT(a_full_starts_count, accept && emit, r_state == ST_COUNT)
    `RMRF_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= rmrf_pkg::CNT_W'(rmrf_pkg::MAX_WINDOW))

endmodule

[rtl/rmrf_cell.sv]
module rmrf_cell (
    input  logic                i_clk,
    input  rmrf_pkg::t_cell_ctl i_ctl,
    input  rmrf_pkg::t_idx      i_index,
    input  rmrf_pkg::t_sample   i_prev_sample,
    input  rmrf_pkg::t_sample   i_next_probe,
    output rmrf_pkg::t_sample   o_sample,
    output rmrf_pkg::t_sample   o_probe,
    output logic                o_hit
);

    rmrf_pkg::t_sample r_sample;
    rmrf_pkg::t_sample r_probe;
    rmrf_pkg::t_cnt    r_rank;
    logic              below;

    // an older equal sample ranks below this one
    assign below = (i_ctl.bcast < r_sample) ||
                   ((i_ctl.bcast == r_sample) && (i_ctl.bcast_idx > i_index));

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_sample <= i_prev_sample;
            r_probe  <= i_prev_sample;
            r_rank   <= rmrf_pkg::CNT_W'(1);
        end else if (i_ctl.count) begin
            r_probe <= i_next_probe;
            if (below) begin
                r_rank <= r_rank + rmrf_pkg::CNT_W'(1);
            end
        end
    end

    assign o_sample = r_sample;
    assign o_probe  = r_probe;
    assign o_hit    = (r_rank == i_ctl.rank_sel) &&
                      ({1'b0, i_index} < i_ctl.len);

endmodule
